@@ rtl/stid_pkg.sv @@
// Shared constants, codes and types for the sorted table block.
`timescale 1ns / 1ps

package stid_pkg;

    localparam int DEPTH  = 16;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 4;
    localparam int REM_W  = 5;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    // Slave-side and master-side beat widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Operation codes (kind)
    localparam logic [KIND_W-1:0] KIND_INS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RD  = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_IDX  = 2'd2;

    // One request to the table memory per cycle: one read, one write
    typedef struct packed {
        logic             rd_en;
        logic [AW-1:0]    rd_addr;
        logic             wr_en;
        logic [AW-1:0]    wr_addr;
        logic [VAL_W-1:0] wr_data;
    } t_ram_req;

endpackage

@@ rtl/stid_ram.sv @@
// Table storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module stid_ram (
    input  logic                     i_clk,
    input  stid_pkg::t_ram_req       i_req,
    output logic [stid_pkg::VAL_W-1:0] o_rdata
);

    logic [stid_pkg::VAL_W-1:0] r_mem [stid_pkg::DEPTH];
    logic [stid_pkg::VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sorted_table_insert_delete.sv @@
// Top level: ascending table of signed values with insert, delete-all-equal and read.
// Read goes via S_RD, insert via S_INS (and S_INS_HEAD), delete via S_DEL, then S_DONE;
//   empty-table insert and no-entry ops (full, bad index, empty, unused kind) skip to S_DONE.
// One operation in flight; the walk through the table memory (one read and at most one write
//   per cycle, one entry per cycle) sets the rate: a new beat is taken only back in S_IDLE.
// Synchronous active-low reset empties the table (count 0) and drops the output beat.
`timescale 1ns / 1ps

module sorted_table_insert_delete (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [stid_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // [31:0] value, [35:32] index,
                                                            // [39:36] zero
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] kind
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [stid_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // [31:0] data, [36:32] removed,
                                                            // [41:37] entry_count, [47:42] zero
    output logic [1:0]  o_m_axis_tuser   // [1:0] status
);

    localparam int AW    = stid_pkg::AW;
    localparam int CNT_W = stid_pkg::CNT_W;
    localparam int VAL_W = stid_pkg::VAL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,       // walk down from the top, moving entries up one place
        S_INS_HEAD,  // walked past entry 0: value goes to the bottom
        S_DEL,       // walk up, compacting survivors
        S_RD,        // read data arrives
        S_DONE       // result ready, wait for the output register
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [VAL_W-1:0] r_val, n_val;
    logic [AW-1:0]    r_ptr, n_ptr;      // address of the read in flight
    logic [CNT_W-1:0] r_wr, n_wr;        // delete: next write position
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [VAL_W-1:0] r_data, n_data;
    logic [stid_pkg::STAT_W-1:0] r_status, n_status;

    // output register
    logic             r_o_valid, n_o_valid;
    logic [VAL_W-1:0] r_o_data, n_o_data;
    logic [CNT_W-1:0] r_o_rem, n_o_rem;
    logic [CNT_W-1:0] r_o_cnt, n_o_cnt;
    logic [stid_pkg::STAT_W-1:0] r_o_status, n_o_status;

    stid_pkg::t_ram_req ram_req;
    logic [VAL_W-1:0]   ram_rdata;

    logic [VAL_W-1:0]          in_value;
    logic [stid_pkg::IDX_W-1:0] in_index;
    logic [stid_pkg::KIND_W-1:0] in_kind;
    logic                      s_fire;
    logic                      hit;
    logic                      last;

    assign in_value = i_s_axis_tdata[31:0];
    assign in_index = i_s_axis_tdata[35:32];
    assign in_kind  = i_s_axis_tuser;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    assign hit  = (ram_rdata == r_val);
    assign last = (CNT_W'(r_ptr) == (r_cnt - CNT_W'(1)));

    stid_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_val      = r_val;
        n_ptr      = r_ptr;
        n_wr       = r_wr;
        n_rem      = r_rem;
        n_data     = r_data;
        n_status   = r_status;
        n_o_valid  = r_o_valid;
        n_o_data   = r_o_data;
        n_o_rem    = r_o_rem;
        n_o_cnt    = r_o_cnt;
        n_o_status = r_o_status;

        ram_req         = '0;
        ram_req.rd_addr = r_ptr;

        if (r_o_valid && i_m_axis_tready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_val    = in_value;
                    n_data   = '0;
                    n_rem    = '0;
                    n_wr     = '0;
                    n_status = stid_pkg::STAT_OK;
                    n_state  = S_DONE;
                    case (in_kind)
                        stid_pkg::KIND_INS: begin
                            if (r_cnt == CNT_W'(stid_pkg::DEPTH)) begin
                                n_status = stid_pkg::STAT_FULL;
                            end else if (r_cnt == '0) begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = '0;
                                ram_req.wr_data = in_value;
                                n_cnt           = CNT_W'(1);
                            end else begin
                                // start at the top entry
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = AW'(r_cnt - CNT_W'(1));
                                n_ptr           = AW'(r_cnt - CNT_W'(1));
                                n_state         = S_INS;
                            end
                        end
                        stid_pkg::KIND_DEL: begin
                            if (r_cnt != '0) begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = '0;
                                n_ptr           = '0;
                                n_state         = S_DEL;
                            end
                        end
                        stid_pkg::KIND_RD: begin
                            if (CNT_W'(in_index) < r_cnt) begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = AW'(in_index);
                                n_state         = S_RD;
                            end else begin
                                n_status = stid_pkg::STAT_IDX;
                            end
                        end
                        default: begin
                            // unused kind: nothing changes
                        end
                    endcase
                end
            end

            S_INS: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = r_ptr + AW'(1);
                if ($signed(ram_rdata) < $signed(r_val)) begin
                    // first smaller entry found: value lands just above it
                    ram_req.wr_data = r_val;
                    n_cnt           = r_cnt + CNT_W'(1);
                    n_state         = S_DONE;
                end else begin
                    ram_req.wr_data = ram_rdata;
                    if (r_ptr == '0) begin
                        n_state = S_INS_HEAD;
                    end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = r_ptr - AW'(1);
                        n_ptr           = r_ptr - AW'(1);
                    end
                end
            end

            S_INS_HEAD: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = '0;
                ram_req.wr_data = r_val;
                n_cnt           = r_cnt + CNT_W'(1);
                n_state         = S_DONE;
            end

            S_DEL: begin
                // write position never passes the read position, so no hazard
                if (hit) begin
                    n_rem = r_rem + CNT_W'(1);
                end else begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = r_wr[AW-1:0];
                    ram_req.wr_data = ram_rdata;
                    n_wr            = r_wr + CNT_W'(1);
                end
                if (last) begin
                    n_cnt   = hit ? r_wr : (r_wr + CNT_W'(1));
                    n_state = S_DONE;
                end else begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = r_ptr + AW'(1);
                    n_ptr           = r_ptr + AW'(1);
                end
            end

            S_RD: begin
                n_data  = ram_rdata;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_o_valid || i_m_axis_tready) begin
                    n_o_valid  = 1'b1;
                    n_o_data   = r_data;
                    n_o_rem    = r_rem;
                    n_o_cnt    = r_cnt;
                    n_o_status = r_status;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
        r_val      <= n_val;
        r_ptr      <= n_ptr;
        r_wr       <= n_wr;
        r_rem      <= n_rem;
        r_data     <= n_data;
        r_status   <= n_status;
        r_o_data   <= n_o_data;
        r_o_rem    <= n_o_rem;
        r_o_cnt    <= n_o_cnt;
        r_o_status <= n_o_status;
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {6'd0, r_o_cnt, r_o_rem, r_o_data};
    assign o_m_axis_tuser  = r_o_status;

endmodule

@@ rtl/stid_checker.sv @@
// Port-level checks for the sorted table block, bound to the top level.
`timescale 1ns / 1ps

module stid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped before accept");

    // count never exceeds table depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[41:37] <= 5'(stid_pkg::DEPTH)))
        else $error("entry count beyond depth");

    // a refused insert reports a full table and no data
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == stid_pkg::STAT_FULL) |->
        (o_m_axis_tdata[41:37] == 5'(stid_pkg::DEPTH)) && (o_m_axis_tdata[36:0] == '0))
        else $error("full status with inconsistent fields");

    // a bad index reads nothing
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == stid_pkg::STAT_IDX) |->
        (o_m_axis_tdata[36:0] == '0))
        else $error("index error with nonzero data");

endmodule

bind sorted_table_insert_delete stid_checker u_stid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
